>>> design/sobel_pkg.sv
package sobel_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic read;
    logic calc;
    logic sqrt_step;
    logic emit_next;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic interior;
    logic sqrt_done;
    logic last_emit;
  } dp_sts_t;

  // one load step plus one step per root bit
  localparam int unsigned SqrtSteps = 12;

endpackage

>>> design/sobel_ctrl.sv
module sobel_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sobel_pkg::dp_cmd_t    cmd_o,
  input  sobel_pkg::dp_sts_t    sts_i
);
  import sobel_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_CALC;
      ST_CALC: begin
        if (!sts_i.interior) state_d = ST_IDLE;
        else if (sts_i.sqrt_done) state_d = ST_EMIT;
      end
      ST_EMIT: if (out_ready_i && sts_i.last_emit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_READ: cmd_o.read = 1'b1;
      ST_CALC: begin
        cmd_o.calc      = 1'b1;
        cmd_o.sqrt_step = sts_i.interior;
      end
      ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_next = out_ready_i;
      end
      default: ;
    endcase
  end
endmodule

>>> design/sobel_dp.sv
module sobel_dp #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         pixel_i,
  input  logic               frame_start_i,
  input  logic [11:0]        image_width_i,
  input  logic [11:0]        image_height_i,
  input  logic [7:0]         edge_threshold_i,
  input  sobel_pkg::dp_cmd_t cmd_i,
  output sobel_pkg::dp_sts_t sts_o,
  output logic [10:0]        out_row_o,
  output logic [10:0]        out_col_o,
  output logic [7:0]         edge_value_o,
  output logic               last_in_run_o
);
  import sobel_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = (AW > $clog2(MAX_HEIGHT) ? AW : $clog2(MAX_HEIGHT)) + 1;

  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] lower_mem [MAX_WIDTH];
  logic [7:0] top_q, mid_q, pix_q;
  logic [23:0] win_q [3];
  logic [PW-1:0] row_q, col_q, r_q, c_q;
  logic [PW-1:0] w, h, r_c, c_c;
  logic [PW-1:0] cr, cc, nr, nc;
  logic signed [11:0] gx, gy;
  logic [21:0] sum_q, rem_q;
  logic [10:0] res_q;
  logic [3:0]  step_q;
  logic [7:0]  mag_q;
  logic [1:0]  ri_q, ci_q;
  logic [2:0]  cnt_q;
  logic [PW-1:0] rows [3];
  logic [PW-1:0] cols [3];
  logic [1:0] nrows, ncols;

  always_comb begin
    if (image_width_i < 12'd3) w = PW'(3);
    else if ({20'd0, image_width_i} > 32'(MAX_WIDTH)) w = PW'(MAX_WIDTH);
    else w = PW'(image_width_i);
    if (image_height_i < 12'd3) h = PW'(3);
    else if ({20'd0, image_height_i} > 32'(MAX_HEIGHT)) h = PW'(MAX_HEIGHT);
    else h = PW'(image_height_i);
  end

  always_comb begin
    r_c = frame_start_i ? '0 : row_q;
    c_c = frame_start_i ? '0 : col_q;
    if (c_c >= w) begin
      c_c = '0;
      r_c = r_c + 1'b1;
    end
    if (r_c >= h) r_c = '0;
    nc = c_c + 1'b1;
    nr = r_c;
    if (nc >= w) begin
      nc = '0;
      nr = r_c + 1'b1;
      if (nr >= h) nr = '0;
    end
  end

  // line stores: read then write same address
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      top_q <= upper_mem[c_c[AW-1:0]];
      mid_q <= lower_mem[c_c[AW-1:0]];
      pix_q <= pixel_i;
      r_q   <= r_c;
      c_q   <= c_c;
    end
    if (cmd_i.read) begin
      upper_mem[c_q[AW-1:0]] <= mid_q;
      lower_mem[c_q[AW-1:0]] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else begin
      if (cmd_i.load) begin
        row_q <= nr;
        col_q <= nc;
      end
      if (cmd_i.read) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= {top_q, mid_q, pix_q};
      end
    end
  end

  always_comb begin
    gx = 12'(win_q[0][23:16]) + 12'({win_q[1][23:16], 1'b0}) + 12'(win_q[2][23:16])
       - 12'(win_q[0][7:0]) - 12'({win_q[1][7:0], 1'b0}) - 12'(win_q[2][7:0]);
    gy = 12'(win_q[0][23:16]) + 12'({win_q[0][15:8], 1'b0}) + 12'(win_q[0][7:0])
       - 12'(win_q[2][23:16]) - 12'({win_q[2][15:8], 1'b0}) - 12'(win_q[2][7:0]);
  end

  assign sts_o.interior = (r_q >= PW'(2)) && (c_q >= PW'(2));
  assign sts_o.sqrt_done = (step_q == 4'(SqrtSteps));

  // restoring square root, one result bit a cycle; step 0 loads the square sum
  logic [21:0] trial;
  logic [1:0]  pair;
  always_comb begin
    pair  = sum_q[21:20];
    trial = {9'd0, res_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.read) begin
      step_q <= '0;
    end else if (cmd_i.sqrt_step && !sts_o.sqrt_done) begin
      step_q <= step_q + 1'b1;
    end
  end

  logic [21:0] rem_n;
  logic [10:0] root;
  always_comb begin
    rem_n = {rem_q[19:0], pair};
    root  = res_q;
  end

  logic [21:0] gx2, gy2;
  always_comb begin
    gx2 = 22'(gx) * 22'(gx);
    gy2 = 22'(gy) * 22'(gy);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      res_q <= '0;
      rem_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      if (step_q == 4'd0) begin
        sum_q <= gx2 + gy2;
        res_q <= '0;
        rem_q <= '0;
      end else if (!sts_o.sqrt_done || step_q < 4'(SqrtSteps)) begin
        sum_q <= {sum_q[19:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q <= rem_n - trial;
          res_q <= {res_q[9:0], 1'b1};
        end else begin
          rem_q <= rem_n;
          res_q <= {res_q[9:0], 1'b0};
        end
      end
    end
  end

  // border copy lists
  always_comb begin
    cr = r_q - 1'b1;
    cc = c_q - 1'b1;
    rows[0] = cr; rows[1] = cr; rows[2] = cr;
    cols[0] = cc; cols[1] = cc; cols[2] = cc;
    nrows = 2'd1;
    ncols = 2'd1;
    if (cr == PW'(1)) begin
      rows[1] = '0;
      nrows = 2'd2;
    end
    if (cr == h - PW'(2)) begin
      rows[nrows] = h - 1'b1;
      nrows = nrows + 1'b1;
    end
    if (cc == PW'(1)) begin
      cols[1] = '0;
      ncols = 2'd2;
    end
    if (cc == w - PW'(2)) begin
      cols[ncols] = w - 1'b1;
      ncols = ncols + 1'b1;
    end
  end

  logic [3:0] total;
  assign total = (4'(nrows) * 4'(ncols) > 4'd4) ? 4'd4 : 4'(nrows) * 4'(ncols);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc && sts_o.sqrt_done) begin
      mag_q <= (root > 11'd255) ? 8'd255 :
               (root[7:0] < edge_threshold_i) ? 8'd0 : root[7:0];
      ri_q  <= '0;
      ci_q  <= '0;
      cnt_q <= 3'd1;
    end else if (cmd_i.emit_next) begin
      cnt_q <= cnt_q + 1'b1;
      if (ci_q + 1'b1 == ncols) begin
        ci_q <= '0;
        ri_q <= ri_q + 1'b1;
      end else begin
        ci_q <= ci_q + 1'b1;
      end
    end
  end

  assign sts_o.last_emit = ({1'b0, cnt_q} == total);
  assign out_row_o     = rows[ri_q][10:0];
  assign out_col_o     = cols[ci_q][10:0];
  assign edge_value_o  = mag_q;
  assign last_in_run_o = sts_o.last_emit;
endmodule

>>> design/sobel_edge_magnitude_3x3.sv
// 3x3 sobel edge magnitude filter over an 8-bit grey pixel stream.
// input channel s_axis: tdata carries the pixel, tuser the frame_start flag
// that puts the position back to row 0, column 0.
// output channel m_axis: tdata carries out_row, out_col and edge_value,
// tlast marks the last result that one input item causes.
// pixels in row 0/1 or column 0/1 give no result; interior centres give one
// result, border neighbours up to four copies, each with its own coordinates.
// each item first passes the idle and read states, which update the line
// stores; an item that makes a result then runs the shared bit-serial
// square root (one result bit a cycle) before its results are emitted.
// items are taken one at a time; a stalled receiver holds the result and
// the input waits until every result of the item is taken.
// reset clears position and window and sets the config registers to 640 x 480, threshold 50;
// line stores hold garbage until written, which a normal frame always does.
module sobel_edge_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // pixel
  input  logic        s_axis_tuser,  // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata, // out_row, out_col, edge_value, zero fill
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import sobel_pkg::*;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;

  logic [11:0] width_q, height_q;
  logic [7:0]  thresh_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [10:0] out_row, out_col;
  logic [7:0]  edge_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 12'd480;
      thresh_q <= 8'd50;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegThresh: thresh_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sobel_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sobel_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .pixel_i          (s_axis_tdata),
    .frame_start_i    (s_axis_tuser),
    .image_width_i    (width_q),
    .image_height_i   (height_q),
    .edge_threshold_i (thresh_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_row_o        (out_row),
    .out_col_o        (out_col),
    .edge_value_o     (edge_value),
    .last_in_run_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, edge_value, out_col, out_row};
endmodule
